// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/dlfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlfr_pkg
// Constants and types of the start/length/end byte frame receiver.
// ----------------------------------------------------------------------------
package dlfr_pkg;

  localparam int MAX_DATA_BYTES = 6;
  localparam int OUT_FIELDS     = 6;
  localparam int BYTE_W         = 8;
  localparam int OUT_W          = OUT_FIELDS * BYTE_W;
  localparam int PHASE_W        = $clog2(MAX_DATA_BYTES + 3);

  localparam logic [BYTE_W-1:0] START_BYTE      = 8'hFF;
  localparam logic [BYTE_W-1:0] END_BYTE        = 8'hFE;
  localparam logic [BYTE_W-1:0] LEN_OFFSET      = 8'd2;
  localparam logic [BYTE_W-1:0] END_PHASE_RESET = 8'd6;

  // Phase codes: idle, length, first data slot, and the sticking phase
  localparam logic [PHASE_W-1:0] PHASE_IDLE  = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PHASE_LEN   = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PHASE_DATA0 = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PHASE_STICK = PHASE_W'(MAX_DATA_BYTES + 2);

  typedef logic [BYTE_W-1:0] data_t;

  // Parser result for one received byte
  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] frame;
  } frame_res_t;

endpackage

// ===== src/dlfr_parser.sv =====
// ----------------------------------------------------------------------------
// dlfr_parser
// Frame phase tracking, length capture and data byte storage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlfr_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  dlfr_pkg::data_t           rx_byte,
  output dlfr_pkg::frame_res_t      res
);

  logic [dlfr_pkg::PHASE_W-1:0]        phase;
  logic [dlfr_pkg::PHASE_W-1:0]        phase_mid;
  logic [dlfr_pkg::PHASE_W-1:0]        phase_next;
  dlfr_pkg::data_t                     end_phase;
  dlfr_pkg::data_t                     end_phase_next;
  dlfr_pkg::data_t                     held_bytes [dlfr_pkg::MAX_DATA_BYTES];
  logic [dlfr_pkg::MAX_DATA_BYTES-1:0] wr_en;
  logic                                is_end;
  logic [dlfr_pkg::OUT_W-1:0]          frame_bytes;

  // Decode the byte against the current phase
  always_comb begin
    is_end         = (rx_byte == dlfr_pkg::END_BYTE);
    res.hit        = is_end && (dlfr_pkg::BYTE_W'(phase) == end_phase);
    res.frame      = frame_bytes;
    phase_mid      = is_end ? dlfr_pkg::PHASE_IDLE : phase;
    phase_next     = phase_mid;
    end_phase_next = end_phase;
    wr_en          = '0;
    if (phase_mid == dlfr_pkg::PHASE_LEN) begin
      end_phase_next = rx_byte + dlfr_pkg::LEN_OFFSET;
      phase_next     = dlfr_pkg::PHASE_DATA0;
    end else if (phase_mid >= dlfr_pkg::PHASE_DATA0 &&
                 phase_mid <  dlfr_pkg::PHASE_STICK) begin
      phase_next = phase_mid + dlfr_pkg::PHASE_W'(1);
      for (int i = 0; i < dlfr_pkg::MAX_DATA_BYTES; i++) begin
        wr_en[i] = (phase_mid == dlfr_pkg::PHASE_W'(i + 2));
      end
    end
    if (rx_byte == dlfr_pkg::START_BYTE) begin
      phase_next = dlfr_pkg::PHASE_LEN;
    end
  end

  // Pack held bytes into the frame, zero past the stored slots
  for (genvar j = 0; j < dlfr_pkg::OUT_FIELDS; j++) begin : g_out
    if (j < dlfr_pkg::MAX_DATA_BYTES) begin : g_held
      assign frame_bytes[j*dlfr_pkg::BYTE_W +: dlfr_pkg::BYTE_W] = held_bytes[j];
    end else begin : g_zero
      assign frame_bytes[j*dlfr_pkg::BYTE_W +: dlfr_pkg::BYTE_W] = '0;
    end
  end

  // Advance state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= dlfr_pkg::PHASE_IDLE;
      end_phase <= dlfr_pkg::END_PHASE_RESET;
      for (int i = 0; i < dlfr_pkg::MAX_DATA_BYTES; i++) begin
        held_bytes[i] <= '0;
      end
    end else if (fire) begin
      phase     <= phase_next;
      end_phase <= end_phase_next;
      for (int i = 0; i < dlfr_pkg::MAX_DATA_BYTES; i++) begin
        if (wr_en[i]) begin
          held_bytes[i] <= rx_byte;
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_phase_range, phase <= dlfr_pkg::PHASE_STICK, "phase out of range")
  `ASSERT_ALWAYS(a_one_slot, $onehot0(wr_en), "more than one slot written")
  `ASSERT_IMPLIES(a_no_write_on_end, is_end, wr_en == '0, "end byte wrote a slot")

endmodule

// ===== src/delimited_length_frame_receiver_core.sv =====
// A completed frame appears on the master side in the cycle after its end byte transfer.
// Throughput: one byte per cycle; the slave side stalls only while a result waits unread.
// The phase logic and the output register form the single pipeline step.
// Reset (rst, synchronous, active high): idle phase, end phase 6, held bytes zero, no result.
// ----------------------------------------------------------------------------
// delimited_length_frame_receiver_core
// Receives a byte stream and emits the held data bytes of each matched frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module delimited_length_frame_receiver_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] rx_byte
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [dlfr_pkg::OUT_W-1:0] m_axis_tdata   // frame_byte_0 .. frame_byte_5, 8 bits each
);

  logic                 in_fire;
  dlfr_pkg::frame_res_t res;

  // Accept while the result register is empty or draining
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  dlfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (in_fire),
    .rx_byte (s_axis_tdata),
    .res     (res)
  );

  // Load a result on a matched end byte, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire && res.hit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.hit) begin
      m_axis_tdata <= res.frame;
    end
  end

  `ASSERT_ALWAYS(a_rise_after_in, $rose(m_axis_tvalid) |-> $past(in_fire && res.hit), "result without end byte")
  `ASSERT_IMPLIES(a_block_on_full, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while result held")
  `ASSERT_ALWAYS(a_hit_loads, in_fire && res.hit |=> m_axis_tvalid, "matched frame lost")

endmodule
